>>> rtl/tdcw_pkg.sv
// shared constants and types for the text display cursor writer
// no dependencies, imported by every rtl module of the block

package tdcw_pkg;

   // geometry defaults
   localparam int LINE_LEN_DEF   = 16;
   localparam int LINE_COUNT_DEF = 3;

   // widths of the result fields
   localparam int ADDR_W = 6;
   localparam int CHAR_W = 8;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // take the new character, apply the pending effect
      logic blank_emit;  // issue one blanking write
      logic print_emit;  // issue the character write at the cursor
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pend_blank;  // pending character is a return or form feed
      logic in_ctrl;     // incoming character is a control code
      logic char_ctrl;   // held character is a control code
      logic blank_done;  // current blanking write is the final one
      logic slot_free;   // output register can take a new write
   } status_type;

   function automatic logic is_ctrl(input logic [CHAR_W-1:0] c);
      return (c == CH_NEWLINE) || (c == CH_RETURN) ||
             (c == CH_BACKSPACE) || (c == CH_FORMFEED);
   endfunction

endpackage

>>> rtl/tdcw_ctrl.sv
// controller state machine for the text display cursor writer
// depends on tdcw_pkg for the command and status types

module tdcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tdcw_pkg::status_type status,
   output tdcw_pkg::cmd_type    cmd
);
   import tdcw_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BLANK = 2'd1;
   localparam logic [1:0] ST_PRINT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.blank_emit = 1'b0;
      cmd.print_emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.pend_blank) begin
                  state_in = ST_BLANK;
               end else if (!status.in_ctrl) begin
                  state_in = ST_PRINT;
               end
            end
         end
         ST_BLANK: begin
            if (status.slot_free) begin
               cmd.blank_emit = 1'b1;
               if (status.blank_done) begin
                  state_in = status.char_ctrl ? ST_IDLE : ST_PRINT;
               end
            end
         end
         ST_PRINT: begin
            if (status.slot_free) begin
               cmd.print_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/tdcw_datapath.sv
// datapath of the text display cursor writer: cursor, pending character,
// blanking counter and output register; depends on tdcw_pkg

module tdcw_datapath #(
   parameter int LINE_LEN   = tdcw_pkg::LINE_LEN_DEF,
   parameter int LINE_COUNT = tdcw_pkg::LINE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tdcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tdcw_pkg::ADDR_W-1:0]   rsp_write_addr,
   output logic [tdcw_pkg::CHAR_W-1:0]   rsp_write_char,
   output logic                          rsp_last_write,
   input  tdcw_pkg::cmd_type             cmd,
   output tdcw_pkg::status_type          status
);
   import tdcw_pkg::*;

   localparam int TOTAL  = LINE_LEN * LINE_COUNT;
   localparam int COL_W  = $clog2(LINE_LEN);
   localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int CELL_W = $clog2(TOTAL);
   localparam int MUL_W  = CELL_W + 1;
   localparam int EXT_W  = (CELL_W > ADDR_W) ? CELL_W : ADDR_W;

   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(LINE_LEN - 1);
   localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(LINE_COUNT - 1);
   localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(TOTAL - 1);
   localparam logic [CELL_W-1:0] LINE_SPAN  = CELL_W'(LINE_LEN - 1);

   // cursor as line and column; past_ff marks one beyond the last cell
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              past_ff, past_in;
   logic [CHAR_W-1:0] pending_ff, pending_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [CELL_W-1:0] blank_addr_ff, blank_addr_in;
   logic [CELL_W-1:0] blank_end_ff, blank_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [MUL_W-1:0]  line_base_w;
   logic [CELL_W-1:0] line_base;
   logic [CELL_W-1:0] cur_addr;
   logic [CELL_W-1:0] wr_addr;
   logic [EXT_W-1:0]  wr_addr_ext;

   assign line_base_w = MUL_W'(line_ff) * MUL_W'(LINE_LEN);
   assign line_base   = line_base_w[CELL_W-1:0];
   assign cur_addr    = line_base + CELL_W'(col_ff);

   assign status.pend_blank = (pending_ff == CH_RETURN) || (pending_ff == CH_FORMFEED);
   assign status.in_ctrl    = is_ctrl(req_char_code);
   assign status.char_ctrl  = is_ctrl(char_ff);
   assign status.blank_done = (blank_addr_ff == blank_end_ff);
   assign status.slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      line_in       = line_ff;
      col_in        = col_ff;
      past_in       = past_ff;
      pending_in    = pending_ff;
      char_in       = char_ff;
      blank_addr_in = blank_addr_ff;
      blank_end_in  = blank_end_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      wr_addr       = cur_addr;
      wr_addr_ext   = EXT_W'(wr_addr);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         char_in    = req_char_code;
         pending_in = req_char_code;
         case (pending_ff)
            CH_NEWLINE: begin
               past_in = 1'b0;
               col_in  = '0;
               line_in = (past_ff || line_ff == LAST_LINE) ? '0 : line_ff + 1'b1;
            end
            CH_RETURN: begin
               past_in       = 1'b0;
               col_in        = '0;
               blank_addr_in = line_base;
               blank_end_in  = line_base + LINE_SPAN;
            end
            CH_BACKSPACE: begin
               if (past_ff) begin
                  past_in = 1'b0;
               end else if (col_ff != '0) begin
                  col_in = col_ff - 1'b1;
               end else if (line_ff != '0) begin
                  line_in = line_ff - 1'b1;
                  col_in  = LAST_COL;
               end
            end
            CH_FORMFEED: begin
               past_in       = 1'b0;
               col_in        = '0;
               line_in       = '0;
               blank_addr_in = '0;
               blank_end_in  = LAST_CELL;
            end
            default: begin
            end
         endcase
      end

      if (cmd.blank_emit) begin
         wr_addr      = blank_addr_ff;
         wr_addr_ext  = EXT_W'(wr_addr);
         rsp_valid_in = 1'b1;
         rsp_addr_in  = wr_addr_ext[ADDR_W-1:0];
         rsp_char_in  = CH_SPACE;
         rsp_last_in  = status.blank_done && status.char_ctrl;
         if (!status.blank_done) begin
            blank_addr_in = blank_addr_ff + 1'b1;
         end
      end

      if (cmd.print_emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_ff;
         rsp_last_in  = 1'b1;
         if (past_ff) begin
            // wrap from one past the end to cell 0
            wr_addr = '0;
            past_in = 1'b0;
            line_in = '0;
            col_in  = COL_W'(1);
         end else begin
            wr_addr = cur_addr;
            if (col_ff == LAST_COL) begin
               if (line_ff == LAST_LINE) begin
                  past_in = 1'b1;
               end else begin
                  line_in = line_ff + 1'b1;
                  col_in  = '0;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         wr_addr_ext = EXT_W'(wr_addr);
         rsp_addr_in = wr_addr_ext[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         col_ff       <= '0;
         past_ff      <= 1'b0;
         pending_ff   <= CH_SPACE;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_ff      <= line_in;
         col_ff       <= col_in;
         past_ff      <= past_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      blank_addr_ff <= blank_addr_in;
      blank_end_ff  <= blank_end_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_addr = rsp_addr_ff;
   assign rsp_write_char = rsp_char_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule

>>> rtl/text_display_cursor_writer.sv
// top level of the text display cursor writer
// instantiates tdcw_ctrl and tdcw_datapath, depends on tdcw_pkg
//
//   channel | direction | transfer carries
//   --------+-----------+--------------------------------------------------
//   req_    | in        | req_char_code, one character byte
//   rsp_    | out       | rsp_write_addr, rsp_write_char, rsp_last_write
//
// a character with no pending effect that writes is taken in the transfer, then
// its write enters the output register once that register is free
// a control character with no pending blanking writes nothing
// unless rsp_ stalls, a pending return adds LINE_LEN writes, a pending form feed
// LINE_LEN * LINE_COUNT, one cell per cycle through the single output register
// synchronous active-high reset: cursor to cell 0, previous character to space
// a stalled rsp_ channel holds the write and pauses the sequence; req_ready is
// low until the current character's writes have all entered the output register

module text_display_cursor_writer #(
   parameter int LINE_LEN   = tdcw_pkg::LINE_LEN_DEF,
   parameter int LINE_COUNT = tdcw_pkg::LINE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // character input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tdcw_pkg::CHAR_W-1:0]   req_char_code,
   // display writes
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tdcw_pkg::ADDR_W-1:0]   rsp_write_addr,
   output logic [tdcw_pkg::CHAR_W-1:0]   rsp_write_char,
   output logic                          rsp_last_write
);
   import tdcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: idle, blanking run, character write
   tdcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // cursor, previous character, blanking counter and output register
   tdcw_datapath #(
      .LINE_LEN   (LINE_LEN),
      .LINE_COUNT (LINE_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_char_code  (req_char_code),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_char (rsp_write_char),
      .rsp_last_write (rsp_last_write),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

>>> rtl/tdcw_checker.sv
// port-level checks for the text display cursor writer
// depends on tdcw_pkg; bound to text_display_cursor_writer below

module tdcw_checker #(
   parameter int LINE_LEN   = tdcw_pkg::LINE_LEN_DEF,
   parameter int LINE_COUNT = tdcw_pkg::LINE_COUNT_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [tdcw_pkg::CHAR_W-1:0]   req_char_code,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tdcw_pkg::ADDR_W-1:0]   rsp_write_addr,
   input logic [tdcw_pkg::CHAR_W-1:0]   rsp_write_char,
   input logic                          rsp_last_write
);
   import tdcw_pkg::*;

   localparam int TOTAL = LINE_LEN * LINE_COUNT;
   localparam bit ADDR_MASKED = (TOTAL > 64);
   localparam logic [ADDR_W:0] TOTAL_CELLS = (ADDR_W + 1)'(ADDR_MASKED ? 0 : TOTAL);

   // a stalled write holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_addr) &&
      $stable(rsp_write_char) && $stable(rsp_last_write))
      else $error("stalled write changed");

   // writes stay inside the display, checked only when it has at most 64 cells
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ADDR_MASKED || ({1'b0, rsp_write_addr} < TOTAL_CELLS))
      else $error("write outside the display");

   // a sequence of writes runs without gaps until its final write
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_write |=> rsp_valid)
      else $error("gap inside a write sequence");

   // no new character while a sequence is unfinished
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_write |-> !req_ready)
      else $error("character taken during a write sequence");

endmodule

bind text_display_cursor_writer tdcw_checker #(
   .LINE_LEN   (LINE_LEN),
   .LINE_COUNT (LINE_COUNT)
) u_tdcw_checker (.*);
